FILE: rtl/trg_pkg.sv
// Shared types, constants and a helper function for the triangular random generator.
// No dependencies; every other file imports this package.
package trg_pkg;

    localparam int FRACTION_BITS_DEF = 16;

    localparam int RANGE_W = 16;
    localparam int SEED_W  = 32;
    localparam int VALUE_W = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAN_HIGH   = 1'd1;

    // item kinds
    localparam logic KIND_DRAW = 1'b0;
    localparam logic KIND_SEED = 1'b1;

    localparam logic [31:0] LCG_MUL   = 32'd2891336453;
    localparam logic [31:0] LCG_ADD   = 32'd1500450271;
    localparam logic [31:0] LCG_MASK  = 32'h7fff_ffff;
    localparam logic [31:0] LCG_START = 32'd1997333137;
    localparam logic [31:0] FRAC_ONE  = 32'h8000_0000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_ROOT,
        ST_MULT,
        ST_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic seed_load;   // load generator state from the item
        logic lcg_mul;     // register state * multiplier
        logic lcg_update;  // finish LCG step, start square root
        logic root_step;   // one digit of the square root
        logic term_mul;    // range * term
        logic out_load;    // clamp and load output register
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;    // output register can take a new item
    } dp_stat_t;

    function automatic logic [31:0] lcg_next(input logic [31:0] s);
        logic [31:0] p;
        p = 32'(s * LCG_MUL);
        return (p + LCG_ADD) & LCG_MASK;
    endfunction

endpackage

FILE: rtl/trg_ctrl.sv
// Controller state machine of the triangular random generator.
// Depends on trg_pkg; drives trg_datapath through dp_cmd_t and reads dp_stat_t.
module trg_ctrl import trg_pkg::*; #(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    input  logic     in_kind,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    localparam int RW = FRACTION_BITS + 1;   // root digits
    localparam int CW = $clog2(RW + 1);

    ctrl_state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid && in_kind == KIND_DRAW) state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                state_next = ST_ROOT;
                cnt_next   = CW'(RW - 1);
            end
            ST_ROOT: begin
                if (cnt_reg == '0) state_next = ST_MULT;
                else               cnt_next   = cnt_reg - 1'b1;
            end
            ST_MULT: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (stat.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready      = 1'b1;
                cmd.seed_load = in_valid && in_kind == KIND_SEED;
                cmd.lcg_mul   = in_valid && in_kind == KIND_DRAW;
            end
            ST_UPDATE: cmd.lcg_update = 1'b1;
            ST_ROOT:   cmd.root_step  = 1'b1;
            ST_MULT:   cmd.term_mul   = 1'b1;
            ST_FINISH: cmd.out_load   = stat.out_free;
            default: ;
        endcase
    end

endmodule

FILE: rtl/trg_datapath.sv
// Datapath of the triangular random generator: LCG state, digit-serial square
// root, range multiply, clamp and output register. Depends on trg_pkg.
module trg_datapath import trg_pkg::*; #(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  dp_cmd_t            cmd,
    output dp_stat_t           stat,
    input  logic [SEED_W-1:0]  seed_value,
    input  logic [RANGE_W-1:0] range_limit,
    input  logic               lean_high,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [VALUE_W-1:0] out_value
);

    localparam int RW  = FRACTION_BITS + 1;          // root width
    localparam int XW  = 2 * RW;                     // radicand, padded to even
    localparam int SHL = (2 * FRACTION_BITS >= 31) ? 2 * FRACTION_BITS - 31 : 0;
    localparam int SHR = (2 * FRACTION_BITS >= 31) ? 0 : 31 - 2 * FRACTION_BITS;
    localparam int PW  = RANGE_W + RW;               // product width

    logic [31:0]        state_reg;
    logic [31:0]        prod_reg;
    logic [XW-1:0]      xs_reg;
    logic [RW+1:0]      rem_reg;
    logic [RW-1:0]      root_reg;
    logic [PW-1:0]      val_reg;
    logic               out_valid_reg;
    logic [VALUE_W-1:0] out_value_reg;

    logic [31:0]        u;
    logic [31:0]        w;
    logic [63:0]        x64;
    logic [RW+1:0]      rem_sh;
    logic [RW+1:0]      trial;
    logic               take;
    logic [RW-1:0]      term;
    logic [RANGE_W-1:0] range_eff;
    logic [PW-1:0]      top;
    logic [PW-1:0]      val_c;
    logic [63:0]        val64;

    assign u = (prod_reg + LCG_ADD) & LCG_MASK;
    assign w = lean_high ? u : FRAC_ONE - u;
    assign x64 = ({32'd0, w} << SHL) >> SHR;

    // one root digit: bring down two radicand bits, try (root << 2) | 1
    assign rem_sh = {rem_reg[RW-1:0], xs_reg[XW-1 -: 2]};
    assign trial  = {root_reg, 2'b01};
    assign take   = rem_sh >= trial;

    assign term = lean_high ? root_reg : RW'(1 << FRACTION_BITS) - root_reg;
    assign range_eff = (range_limit == '0) ? RANGE_W'(1) : range_limit;

    // term never exceeds one, so the clamp only hits term == one exactly
    assign top   = PW'(range_eff) << FRACTION_BITS;
    assign val_c = (val_reg >= top) ? PW'(range_eff - 1'b1) << FRACTION_BITS : val_reg;
    assign val64 = 64'(val_c);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lcg_next(LCG_START);
        end else if (cmd.seed_load) begin
            state_reg <= seed_value;
        end else if (cmd.lcg_update) begin
            state_reg <= u;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.lcg_mul) prod_reg <= 32'(state_reg * LCG_MUL);
        if (cmd.lcg_update) begin
            xs_reg   <= x64[XW-1:0];
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (cmd.root_step) begin
            xs_reg   <= {xs_reg[XW-3:0], 2'b00};
            rem_reg  <= take ? rem_sh - trial : rem_sh;
            root_reg <= {root_reg[RW-2:0], take};
        end
        if (cmd.term_mul) val_reg <= PW'(range_eff * term);
        if (cmd.out_load) out_value_reg <= (val64 > 64'hFFFF_FFFF) ? '1 : val64[31:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign out_value     = out_value_reg;

endmodule

FILE: rtl/triangular_random_generator.sv
// Top level of the triangular random generator: configuration registers and
// the controller/datapath pair. Depends on trg_pkg, trg_ctrl, trg_datapath.
//
//  channel  dir  handshake          payload
//  s_       in   s_tvalid/s_tready  s_tdata = seed_value, s_tuser = kind
//  m_       out  m_tvalid/m_tready  m_tdata = value
//  cfg_     in   cfg_wr_en          cfg_wr_index, cfg_wr_data
//
// A draw runs the LCG multiply and update, the square root, one digit per cycle
// over FRACTION_BITS + 1 digits, and the range multiply, then loads its result;
// the next item is taken in the cycle after the load. A seed item loads the
// generator state and gives no result. Reset (aresetn low, synchronous) clears
// the controller, configuration and output-valid registers and loads the first
// generator step. A stalled result holds in the output register; the next
// item is still taken and waits before loading its result.
module triangular_random_generator import trg_pkg::*; #(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [SEED_W-1:0]     s_tdata,   // [31:0] seed_value
    input  logic                  s_tuser,   // [0] kind
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [VALUE_W-1:0]    m_tdata,   // [31:0] value
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

    logic [RANGE_W-1:0] range_limit_reg;
    logic               lean_high_reg;
    dp_cmd_t            cmd;
    dp_stat_t           stat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_limit_reg <= '0;
            lean_high_reg   <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                CFG_RANGE_LIMIT: range_limit_reg <= cfg_wr_data[RANGE_W-1:0];
                CFG_LEAN_HIGH:   lean_high_reg   <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    trg_ctrl #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_kind  (s_tuser),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    trg_datapath #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .seed_value  (s_tdata),
        .range_limit (range_limit_reg),
        .lean_high   (lean_high_reg),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_value   (m_tdata)
    );

endmodule
